@@ rtl/core/refcounted_dedup_slot_table_top_assert.svh @@
// Assertion macros for the slot table.
`ifndef REFCOUNTED_DEDUP_SLOT_TABLE_TOP_ASSERT_SVH
`define REFCOUNTED_DEDUP_SLOT_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
// The condition must never hold outside reset.
`define RDST_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rdst: forbidden condition seen");
// The consequence must hold in the cycle after the cause.
`define RDST_ASSERT_NEXT(lbl, clk, cause, cons) \
    lbl: assert property (@(posedge clk) (cause) |=> (cons)) \
        else $error("rdst: expected follow-up missing");
`else
`define RDST_ASSERT_NEVER(lbl, clk, rstn, cond)
`define RDST_ASSERT_NEXT(lbl, clk, cause, cons)
`endif
`endif

@@ rtl/core/rdst_pkg.sv @@
`default_nettype none
package rdst_pkg;
    localparam int DEF_SLOT_COUNT        = 64;
    localparam int DEF_MAX_PAYLOAD_BYTES = 8;
    localparam int DEF_TYPE_BITS         = 16;
    localparam int KIND_BITS             = 3;
    localparam int HASH_BITS             = 32;
    localparam int COUNT_BITS            = 16;
    localparam int DATA_BITS             = 64;
    localparam int SIZE_BITS             = 4;
    localparam int STATUS_BITS           = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACQUIRE = 3'd0,
        KIND_ADD_REF = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_QUERY   = 3'd3,
        KIND_FIND    = 3'd4,
        KIND_CLEAR   = 3'd5
    } t_kind;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNUSED   = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
endpackage
`default_nettype wire

@@ rtl/core/rdst_ram.sv @@
`default_nettype none
module rdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, registered read, read returns the old word on a write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/rdst_front.sv @@
`default_nettype none
module rdst_front #(
    parameter int SLOT_COUNT        = rdst_pkg::DEF_SLOT_COUNT,
    parameter int MAX_PAYLOAD_BYTES = rdst_pkg::DEF_MAX_PAYLOAD_BYTES,
    parameter int TYPE_BITS         = rdst_pkg::DEF_TYPE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [rdst_pkg::KIND_BITS-1:0]    i_kind,
    input  wire logic [TYPE_BITS-1:0]              i_type_id,
    input  wire logic [rdst_pkg::HASH_BITS-1:0]    i_content_hash,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]     i_slot_index,
    input  wire logic [rdst_pkg::DATA_BITS-1:0]    i_payload,
    input  wire logic [rdst_pkg::SIZE_BITS-1:0]    i_payload_size,
    output logic                                   o_cmd_valid,
    input  wire logic                              i_cmd_pop,
    output logic [rdst_pkg::KIND_BITS-1:0]         o_kind,
    output logic [TYPE_BITS-1:0]                   o_type,
    output logic [rdst_pkg::HASH_BITS-1:0]         o_hash,
    output logic [$clog2(SLOT_COUNT)-1:0]          o_idx,
    output logic [rdst_pkg::DATA_BITS-1:0]         o_payload,
    output logic [rdst_pkg::SIZE_BITS-1:0]         o_size
);
    import rdst_pkg::*;
    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [SIZE_BITS-1:0] MAXB = SIZE_BITS'(MAX_PAYLOAD_BYTES);

    logic [SIZE_BITS-1:0] s_size;
    logic [DATA_BITS-1:0] s_pay;
    logic [KIND_BITS-1:0] r_kind [2];
    logic [TYPE_BITS-1:0] r_type [2];
    logic [HASH_BITS-1:0] r_hash [2];
    logic [IW-1:0]        r_idx  [2];
    logic [DATA_BITS-1:0] r_pay  [2];
    logic [SIZE_BITS-1:0] r_size [2];
    logic                 r_wr, r_rd;
    logic [1:0]           r_cnt;
    logic                 s_push, s_pop;

    // Clamp the size and keep only the valid payload bytes.
    always_comb begin
        s_size = (i_payload_size > MAXB) ? MAXB : i_payload_size;
        for (int b = 0; b < DATA_BITS / 8; b++) begin
            s_pay[b*8 +: 8] = (SIZE_BITS'(b) < s_size) ? i_payload[b*8 +: 8] : 8'd0;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign s_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign s_pop       = i_cmd_pop && o_cmd_valid;

    // Two-entry queue between the front and the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_push) begin
                r_wr <= ~r_wr;
            end
            if (s_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, s_push} - {1'b0, s_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_kind[r_wr] <= i_kind;
            r_type[r_wr] <= i_type_id;
            r_hash[r_wr] <= i_content_hash;
            r_idx[r_wr]  <= i_slot_index;
            r_pay[r_wr]  <= s_pay;
            r_size[r_wr] <= s_size;
        end
    end

    assign o_kind    = r_kind[r_rd];
    assign o_type    = r_type[r_rd];
    assign o_hash    = r_hash[r_rd];
    assign o_idx     = r_idx[r_rd];
    assign o_payload = r_pay[r_rd];
    assign o_size    = r_size[r_rd];
endmodule
`default_nettype wire

@@ rtl/core/rdst_back.sv @@
`default_nettype none
module rdst_back #(
    parameter int SLOT_COUNT = rdst_pkg::DEF_SLOT_COUNT,
    parameter int TYPE_BITS  = rdst_pkg::DEF_TYPE_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_valid,
    output logic                                 o_cmd_pop,
    input  wire logic [rdst_pkg::KIND_BITS-1:0]  i_kind,
    input  wire logic [TYPE_BITS-1:0]            i_type,
    input  wire logic [rdst_pkg::HASH_BITS-1:0]  i_hash,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]   i_idx,
    input  wire logic [rdst_pkg::DATA_BITS-1:0]  i_payload,
    input  wire logic [rdst_pkg::SIZE_BITS-1:0]  i_size,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [rdst_pkg::STATUS_BITS-1:0]     o_status,
    output logic [$clog2(SLOT_COUNT)-1:0]        o_result_index,
    output logic                                 o_reused,
    output logic [rdst_pkg::COUNT_BITS-1:0]      o_ref_count,
    output logic [rdst_pkg::DATA_BITS-1:0]       o_data_out,
    output logic [rdst_pkg::SIZE_BITS-1:0]       o_size_out,
    output logic                                 o_ref_valid,
    output logic [$clog2(SLOT_COUNT):0]          o_live_slots
);
    import rdst_pkg::*;
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int EW = TYPE_BITS + HASH_BITS + COUNT_BITS + DATA_BITS + SIZE_BITS;
    localparam logic [IW:0] NSLOT = (IW+1)'(SLOT_COUNT);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CHK = 7'b0000100,
        S_RESOLVE  = 7'b0001000,
        S_IDX_RD   = 7'b0010000,
        S_IDX_CHK  = 7'b0100000,
        S_ALLOC    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [KIND_BITS-1:0] r_kind, n_kind;
    logic [TYPE_BITS-1:0] r_type, n_type, r_ktype, n_ktype;
    logic [HASH_BITS-1:0] r_hash, n_hash, r_khash, n_khash;
    logic [IW-1:0] r_idx, n_idx, r_i, n_i, r_hit, n_hit, r_slot, n_slot;
    logic [DATA_BITS-1:0] r_pay, n_pay, r_hdata, n_hdata;
    logic [SIZE_BITS-1:0] r_size, n_size, r_hlen, n_hlen;
    logic [COUNT_BITS-1:0] r_hcnt, n_hcnt;
    logic r_found, n_found, r_from_free, n_from_free;
    logic [SLOT_COUNT-1:0] r_live, n_live, r_listed, n_listed;
    logic [IW:0] r_created, n_created, r_depth, n_depth, r_total, n_total;
    logic r_ov, n_ov;
    logic [STATUS_BITS-1:0] r_ost, n_ost;
    logic [IW-1:0] r_oidx, n_oidx;
    logic r_oreuse, n_oreuse, r_orv, n_orv;
    logic [COUNT_BITS-1:0] r_ocnt, n_ocnt;
    logic [DATA_BITS-1:0] r_odata, n_odata;
    logic [SIZE_BITS-1:0] r_osize, n_osize;
    logic [IW:0] r_olive, n_olive;
    logic s_fin;

    // Slot memory and free stack.
    logic          s_we, s_fwe;
    logic [IW-1:0] s_addr, s_faddr, s_fwdata, s_frd, s_aslot;
    logic [EW-1:0] s_wdata, s_rd;
    logic [TYPE_BITS-1:0]  s_rtype;
    logic [HASH_BITS-1:0]  s_rhash;
    logic [COUNT_BITS-1:0] s_rcnt;
    logic [DATA_BITS-1:0]  s_rdata;
    logic [SIZE_BITS-1:0]  s_rlen;

    rdst_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_slot_mem (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wdata), .o_rdata(s_rd)
    );
    rdst_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_free_mem (
        .i_clk(i_clk), .i_we(s_fwe), .i_addr(s_faddr), .i_wdata(s_fwdata), .o_rdata(s_frd)
    );

    assign {s_rtype, s_rhash, s_rcnt, s_rdata, s_rlen} = s_rd;
    assign s_aslot   = r_from_free ? s_frd : r_slot;
    assign o_cmd_pop = (r_state == S_IDLE) && !r_ov && i_cmd_valid;

    // Sequencer: while scanning, each slot visited takes a read state and then a check state.
    always_comb begin
        n_state = r_state; n_kind = r_kind; n_type = r_type; n_hash = r_hash;
        n_ktype = r_ktype; n_khash = r_khash; n_idx = r_idx; n_i = r_i;
        n_hit = r_hit; n_slot = r_slot; n_pay = r_pay; n_hdata = r_hdata;
        n_size = r_size; n_hlen = r_hlen; n_hcnt = r_hcnt; n_found = r_found;
        n_from_free = r_from_free; n_live = r_live; n_listed = r_listed;
        n_created = r_created; n_depth = r_depth; n_total = r_total;
        n_ov = r_ov; n_ost = r_ost; n_oidx = r_oidx; n_oreuse = r_oreuse;
        n_orv = r_orv; n_ocnt = r_ocnt; n_odata = r_odata; n_osize = r_osize;
        n_olive = r_olive;
        s_fin = 1'b0;
        s_we = 1'b0; s_addr = r_i; s_wdata = s_rd;
        s_fwe = 1'b0; s_faddr = r_depth[IW-1:0]; s_fwdata = r_idx;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_kind = i_kind; n_type = i_type; n_hash = i_hash;
                    n_ktype = i_type; n_khash = i_hash; n_idx = i_idx;
                    n_pay = i_payload; n_size = i_size;
                    n_i = '0; n_found = 1'b0; n_from_free = 1'b0;
                    n_ost = ST_REJECTED; n_oidx = '0; n_oreuse = 1'b0;
                    n_orv = 1'b0; n_ocnt = '0; n_odata = '0; n_osize = '0;
                    priority case (i_kind)
                        KIND_ACQUIRE, KIND_FIND: begin
                            n_state = (r_created == '0) ? S_RESOLVE : S_SCAN_RD;
                        end
                        KIND_ADD_REF, KIND_RELEASE, KIND_QUERY: begin
                            if ({1'b0, i_idx} < r_created && r_live[i_idx]) begin
                                n_state = S_IDX_RD;
                            end else begin
                                s_fin = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_live = '0; n_listed = '0; n_created = '0;
                            n_depth = '0; n_total = '0; n_ost = ST_OK;
                            s_fin = 1'b1;
                        end
                        default: begin
                            s_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                s_addr = r_i;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_listed[r_i] && s_rtype == r_ktype && s_rhash == r_khash) begin
                    n_found = 1'b1; n_hit = r_i;
                    n_hdata = s_rdata; n_hlen = s_rlen; n_hcnt = s_rcnt;
                    n_state = S_RESOLVE;
                end else if (({1'b0, r_i} + 1'b1) == r_created) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_RESOLVE: begin
                priority case (r_kind)
                    KIND_FIND: begin
                        if (r_found) begin
                            n_ost = ST_OK; n_oidx = r_hit;
                        end
                        s_fin = 1'b1;
                    end
                    KIND_RELEASE: begin
                        if (r_found) begin
                            n_listed[r_hit] = 1'b0;
                        end
                        n_ost = ST_OK;
                        s_fin = 1'b1;
                    end
                    default: begin
                        if (r_found && r_live[r_hit] && r_hlen == r_size &&
                                r_hdata == r_pay) begin
                            // Hit on an identical payload: bump the count.
                            s_addr = r_hit; s_we = 1'b1;
                            s_wdata = {r_ktype, r_khash,
                                       (r_hcnt == COUNT_MAX) ? r_hcnt : r_hcnt + 1'b1,
                                       r_hdata, r_hlen};
                            n_ost = ST_OK; n_oidx = r_hit; n_oreuse = 1'b1;
                            s_fin = 1'b1;
                        end else if (r_depth != '0) begin
                            // Pop the free stack; the word arrives next cycle.
                            s_faddr = IW'(r_depth - 1'b1);
                            n_depth = r_depth - 1'b1;
                            n_from_free = 1'b1;
                            n_state = S_ALLOC;
                        end else if (r_created < NSLOT) begin
                            n_slot = r_created[IW-1:0];
                            n_created = r_created + 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            n_ost = ST_FULL;
                            s_fin = 1'b1;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                if (r_found) begin
                    n_listed[r_hit] = 1'b0;
                end
                s_addr = s_aslot; s_we = 1'b1;
                s_wdata = {r_type, r_hash, COUNT_BITS'(1), r_pay, r_size};
                if (!r_live[s_aslot]) begin
                    n_total = r_total + 1'b1;
                end
                n_live[s_aslot] = 1'b1;
                n_listed[s_aslot] = 1'b1;
                n_ost = ST_OK; n_oidx = s_aslot;
                s_fin = 1'b1;
            end
            S_IDX_RD: begin
                s_addr = r_idx;
                n_state = S_IDX_CHK;
            end
            S_IDX_CHK: begin
                s_addr = r_idx;
                if (s_rhash != r_hash) begin
                    s_fin = 1'b1;
                end else begin
                    priority case (r_kind)
                        KIND_ADD_REF: begin
                            s_we = 1'b1;
                            s_wdata = {s_rtype, s_rhash,
                                       (s_rcnt == COUNT_MAX) ? s_rcnt : s_rcnt + 1'b1,
                                       s_rdata, s_rlen};
                            n_ost = ST_OK;
                            s_fin = 1'b1;
                        end
                        KIND_QUERY: begin
                            n_ost = ST_OK; n_ocnt = s_rcnt; n_odata = s_rdata;
                            n_osize = s_rlen; n_orv = (s_rtype == r_type);
                            s_fin = 1'b1;
                        end
                        default: begin
                            if (s_rcnt == '0) begin
                                s_fin = 1'b1;
                            end else if (s_rcnt != COUNT_BITS'(1)) begin
                                s_we = 1'b1;
                                s_wdata = {s_rtype, s_rhash, s_rcnt - 1'b1, s_rdata, s_rlen};
                                n_ost = ST_OK;
                                s_fin = 1'b1;
                            end else begin
                                // Last reference: free the slot, then unlist its key.
                                s_we = 1'b1;
                                s_wdata = {s_rtype, s_rhash, {COUNT_BITS{1'b0}},
                                           {DATA_BITS{1'b0}}, {SIZE_BITS{1'b0}}};
                                n_live[r_idx] = 1'b0;
                                if (r_total != '0) begin
                                    n_total = r_total - 1'b1;
                                end
                                if (r_depth < NSLOT) begin
                                    s_fwe = 1'b1;
                                    n_depth = r_depth + 1'b1;
                                end
                                n_ktype = s_rtype; n_khash = s_rhash;
                                n_i = '0; n_found = 1'b0;
                                n_state = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (s_fin) begin
            n_ov = 1'b1;
            n_olive = n_total;
            n_state = S_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_listed  <= '0;
            r_created <= '0;
            r_depth   <= '0;
            r_total   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_listed  <= n_listed;
            r_created <= n_created;
            r_depth   <= n_depth;
            r_total   <= n_total;
            r_ov      <= n_ov;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_type <= n_type; r_hash <= n_hash;
        r_ktype <= n_ktype; r_khash <= n_khash; r_idx <= n_idx; r_i <= n_i;
        r_hit <= n_hit; r_slot <= n_slot; r_pay <= n_pay; r_hdata <= n_hdata;
        r_size <= n_size; r_hlen <= n_hlen; r_hcnt <= n_hcnt; r_found <= n_found;
        r_from_free <= n_from_free;
        r_ost <= n_ost; r_oidx <= n_oidx; r_oreuse <= n_oreuse; r_orv <= n_orv;
        r_ocnt <= n_ocnt; r_odata <= n_odata; r_osize <= n_osize; r_olive <= n_olive;
    end

    assign o_valid        = r_ov;
    assign o_status       = r_ost;
    assign o_result_index = r_oidx;
    assign o_reused       = r_oreuse;
    assign o_ref_count    = r_ocnt;
    assign o_data_out     = r_odata;
    assign o_size_out     = r_osize;
    assign o_ref_valid    = r_orv;
    assign o_live_slots   = r_olive;
endmodule
`default_nettype wire

@@ rtl/core/refcounted_dedup_slot_table_top.sv @@
// Channel   Direction  tdata fields (lowest bit up)                       tuser
// s_axis    in         type_id, content_hash, slot_index, payload, size   kind
// m_axis    out        status, result_index, reused, ref_count, data_out,
//                      size_out, ref_valid, live_slots                    -
// Add_ref, query and hash rejections pass through a slot read and a check state; clear,
// unknown kinds and index rejections are answered straight from idle.
// Acquire and find scan the slot memory with a read and a check per slot, then resolve.
// A release to zero scans in the same way to unlist its key.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A two-entry queue keeps accepting, until it is full, while a result waits on m_axis.
`default_nettype none
`include "refcounted_dedup_slot_table_top_assert.svh"
module refcounted_dedup_slot_table_top #(
    parameter int SLOT_COUNT        = rdst_pkg::DEF_SLOT_COUNT,
    parameter int MAX_PAYLOAD_BYTES = rdst_pkg::DEF_MAX_PAYLOAD_BYTES,
    parameter int TYPE_BITS         = rdst_pkg::DEF_TYPE_BITS,
    localparam int IW  = $clog2(SLOT_COUNT),
    localparam int IWD = TYPE_BITS + rdst_pkg::HASH_BITS + IW + rdst_pkg::DATA_BITS
                         + rdst_pkg::SIZE_BITS,
    localparam int OWD = rdst_pkg::STATUS_BITS + IW + 1 + rdst_pkg::COUNT_BITS
                         + rdst_pkg::DATA_BITS + rdst_pkg::SIZE_BITS + 1 + IW + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // type_id, content_hash, slot_index, payload, payload_size
    input  wire logic [((IWD+7)/8)*8-1:0]       i_s_tdata,
    // kind
    input  wire logic [rdst_pkg::KIND_BITS-1:0] i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // status, result_index, reused, ref_count, data_out, size_out, ref_valid, live_slots
    output logic [((OWD+7)/8)*8-1:0]            o_m_tdata
);
    import rdst_pkg::*;
    localparam int OWP = ((OWD+7)/8)*8;

    logic [TYPE_BITS-1:0] s_type;
    logic [HASH_BITS-1:0] s_hash;
    logic [IW-1:0]        s_idx;
    logic [DATA_BITS-1:0] s_pay;
    logic [SIZE_BITS-1:0] s_size;

    assign {s_size, s_pay, s_idx, s_hash, s_type} = i_s_tdata[IWD-1:0];

    logic                 c_valid, c_pop;
    logic [KIND_BITS-1:0] c_kind;
    logic [TYPE_BITS-1:0] c_type;
    logic [HASH_BITS-1:0] c_hash;
    logic [IW-1:0]        c_idx;
    logic [DATA_BITS-1:0] c_pay;
    logic [SIZE_BITS-1:0] c_size;

    rdst_front #(
        .SLOT_COUNT(SLOT_COUNT), .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
        .TYPE_BITS(TYPE_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_kind(i_s_tuser), .i_type_id(s_type), .i_content_hash(s_hash),
        .i_slot_index(s_idx), .i_payload(s_pay), .i_payload_size(s_size),
        .o_cmd_valid(c_valid), .i_cmd_pop(c_pop), .o_kind(c_kind), .o_type(c_type),
        .o_hash(c_hash), .o_idx(c_idx), .o_payload(c_pay), .o_size(c_size)
    );

    logic [STATUS_BITS-1:0] r_status;
    logic [IW-1:0]          r_index;
    logic                   r_reused, r_rvalid;
    logic [COUNT_BITS-1:0]  r_count;
    logic [DATA_BITS-1:0]   r_data;
    logic [SIZE_BITS-1:0]   r_sizeo;
    logic [IW:0]            r_live;

    rdst_back #(.SLOT_COUNT(SLOT_COUNT), .TYPE_BITS(TYPE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(c_valid), .o_cmd_pop(c_pop),
        .i_kind(c_kind), .i_type(c_type), .i_hash(c_hash), .i_idx(c_idx),
        .i_payload(c_pay), .i_size(c_size), .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_status(r_status), .o_result_index(r_index), .o_reused(r_reused),
        .o_ref_count(r_count), .o_data_out(r_data), .o_size_out(r_sizeo),
        .o_ref_valid(r_rvalid), .o_live_slots(r_live)
    );

    assign o_m_tdata = OWP'({r_live, r_rvalid, r_sizeo, r_data, r_count, r_reused,
                             r_index, r_status});

    // Result checks.
    `RDST_ASSERT_NEVER(a_no_unused_status, i_clk, i_rst_n, o_m_tvalid && r_status == ST_UNUSED)
    `RDST_ASSERT_NEVER(a_live_bound, i_clk, i_rst_n, o_m_tvalid && r_live > (IW+1)'(SLOT_COUNT))
    `RDST_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_m_tvalid)
endmodule
`default_nettype wire

@@ dv/refcounted_dedup_slot_table_top_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module refcounted_dedup_slot_table_top_tb;
    import rdst_pkg::*;

    localparam int SLOTS = 64;
    localparam int IDXW  = 6;
    localparam int IN_W  = 16 + 32 + IDXW + 64 + 4;
    localparam int OUT_W = 2 + IDXW + 1 + 16 + 64 + 4 + 1 + IDXW + 1;
    localparam int IN_PW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

    // One operation as the block receives it.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] type_id;
        logic [31:0] content_hash;
        logic [5:0]  slot_index;
        logic [63:0] payload;
        logic [3:0]  payload_size;
    } t_op;

    // One answer as the block returns it, status in the lowest bits.
    typedef struct packed {
        logic [6:0]  live_slots;
        logic        ref_valid;
        logic [3:0]  size_out;
        logic [63:0] data_out;
        logic [15:0] ref_count;
        logic        reused;
        logic [5:0]  result_index;
        logic [1:0]  status;
    } t_answer;

    // Predicts the slot table and holds the answers still owed by the block.
    class slot_table_scoreboard;
        bit          live[SLOTS];
        bit          listed[SLOTS];
        logic [15:0] s_type[SLOTS];
        logic [31:0] s_hash[SLOTS];
        logic [15:0] s_count[SLOTS];
        logic [63:0] s_data[SLOTS];
        logic [3:0]  s_len[SLOTS];
        logic [5:0]  free_stack[SLOTS];
        int          created;
        int          free_depth;
        int          live_total;
        t_answer     pending[$];
        int          mismatches;
        int          checked;
        int          n_full;
        int          n_reused;

        function void empty_table();
            for (int i = 0; i < SLOTS; i++) begin
                live[i] = 0;
                listed[i] = 0;
            end
            created = 0;
            free_depth = 0;
            live_total = 0;
        endfunction

        function int listed_slot(logic [15:0] t, logic [31:0] h);
            for (int i = 0; i < created; i++)
                if (listed[i] && s_type[i] == t && s_hash[i] == h)
                    return i;
            return -1;
        endfunction

        function bit reference_ok(logic [5:0] idx, logic [31:0] h);
            return idx < created && live[idx] && s_hash[idx] == h;
        endfunction

        // Works out the answer to an accepted operation and records it.
        function void note_transfer(t_op op);
            t_answer a;
            int hit;
            int slot;
            int sz;
            logic [63:0] pl;
            a = '0;
            a.status = ST_REJECTED;
            sz = (op.payload_size > 8) ? 8 : op.payload_size;
            pl = (sz >= 8) ? op.payload : op.payload & ((64'd1 << (sz * 8)) - 1);
            case (op.kind)
                KIND_ACQUIRE: begin
                    hit = listed_slot(op.type_id, op.content_hash);
                    if (hit >= 0 && live[hit] && s_len[hit] == sz && s_data[hit] == pl) begin
                        if (s_count[hit] != COUNT_MAX) s_count[hit]++;
                        a.status = ST_OK;
                        a.result_index = 6'(hit);
                        a.reused = 1;
                        n_reused++;
                    end else begin
                        slot = -1;
                        if (free_depth > 0) begin
                            free_depth--;
                            slot = free_stack[free_depth];
                        end else if (created < SLOTS) begin
                            slot = created;
                            created++;
                        end
                        if (slot < 0) begin
                            a.status = ST_FULL;
                            n_full++;
                        end else begin
                            if (hit >= 0) listed[hit] = 0;
                            s_type[slot] = op.type_id;
                            s_hash[slot] = op.content_hash;
                            s_count[slot] = 16'd1;
                            s_data[slot] = pl;
                            s_len[slot] = 4'(sz);
                            if (!live[slot]) live_total++;
                            live[slot] = 1;
                            listed[slot] = 1;
                            a.status = ST_OK;
                            a.result_index = 6'(slot);
                        end
                    end
                end
                KIND_ADD_REF: begin
                    if (reference_ok(op.slot_index, op.content_hash)) begin
                        if (s_count[op.slot_index] != COUNT_MAX) s_count[op.slot_index]++;
                        a.status = ST_OK;
                    end
                end
                KIND_RELEASE: begin
                    if (reference_ok(op.slot_index, op.content_hash)
                        && s_count[op.slot_index] != 0) begin
                        a.status = ST_OK;
                        s_count[op.slot_index]--;
                        if (s_count[op.slot_index] == 0) begin
                            hit = listed_slot(s_type[op.slot_index], s_hash[op.slot_index]);
                            if (hit >= 0) listed[hit] = 0;
                            live[op.slot_index] = 0;
                            s_data[op.slot_index] = '0;
                            s_len[op.slot_index] = '0;
                            if (live_total > 0) live_total--;
                            if (free_depth < SLOTS) begin
                                free_stack[free_depth] = op.slot_index;
                                free_depth++;
                            end
                        end
                    end
                end
                KIND_QUERY: begin
                    if (reference_ok(op.slot_index, op.content_hash)) begin
                        a.status = ST_OK;
                        a.ref_count = s_count[op.slot_index];
                        a.data_out = s_data[op.slot_index];
                        a.size_out = s_len[op.slot_index];
                        a.ref_valid = (s_type[op.slot_index] == op.type_id);
                    end
                end
                KIND_FIND: begin
                    hit = listed_slot(op.type_id, op.content_hash);
                    if (hit >= 0) begin
                        a.status = ST_OK;
                        a.result_index = 6'(hit);
                    end
                end
                KIND_CLEAR: begin
                    empty_table();
                    a.status = ST_OK;
                end
                default: ;
            endcase
            a.live_slots = 7'(live_total);
            pending.insert(pending.size(), a);
        endfunction

        // Compares one answer from the block with the oldest one owed.
        function void check_answer(t_answer got);
            t_answer want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected answer %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: answer %0d (exp/got): st %0d/%0d idx %0d/%0d reu %0d/%0d",
                        checked, want.status, got.status, want.result_index,
                        got.result_index, want.reused, got.reused);
                    $display("  cnt %0d/%0d dat %h/%h sz %0d/%0d val %0d/%0d live %0d/%0d",
                        want.ref_count, got.ref_count, want.data_out, got.data_out,
                        want.size_out, got.size_out, want.ref_valid, got.ref_valid,
                        want.live_slots, got.live_slots);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    // type_id, content_hash, slot_index, payload, payload_size
    logic [IN_PW-1:0]  i_s_tdata;
    // kind
    logic [2:0]        i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    // status, result_index, reused, ref_count, data_out, size_out, ref_valid, live_slots
    logic [OUT_PW-1:0] o_m_tdata;

    slot_table_scoreboard sb;
    bit   idle_enable;
    bit   hold_off;
    int   n_items;

    // The last 40 handles handed out, so that most references name real slots.
    logic [5:0]  known_idx[$];
    logic [31:0] known_hash[$];
    logic [15:0] known_type[$];

    refcounted_dedup_slot_table_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Offers one operation and waits for its transfer.
    task automatic send_op(t_op op);
        logic [IN_PW-1:0] d;
        while (idle_enable && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        d = '0;
        d[15:0]    = op.type_id;
        d[47:16]   = op.content_hash;
        d[53:48]   = op.slot_index;
        d[117:54]  = op.payload;
        d[121:118] = op.payload_size;
        i_s_tdata  <= d;
        i_s_tuser  <= op.kind;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_transfer(op);
        if (op.kind == KIND_ACQUIRE) begin
            known_idx.insert(known_idx.size(), sb.pending[$].result_index);
            known_hash.insert(known_hash.size(), op.content_hash);
            known_type.insert(known_type.size(), op.type_id);
            if (known_idx.size() > 40) begin
                void'(known_idx.pop_front());
                void'(known_hash.pop_front());
                void'(known_type.pop_front());
            end
        end
        n_items++;
    endtask

    function automatic t_op make_op(logic [2:0] k, logic [15:0] t, logic [31:0] h,
                                    logic [5:0] idx, logic [63:0] p, logic [3:0] s);
        t_op op;
        op.kind = k;
        op.type_id = t;
        op.content_hash = h;
        op.slot_index = idx;
        op.payload = p;
        op.payload_size = s;
        return op;
    endfunction

    // Random operation biased towards well-formed references to live slots.
    function automatic t_op random_op();
        t_op op;
        int  r;
        int  j;
        op = make_op(3'($urandom_range(4)), 16'($urandom_range(3)), 32'($urandom_range(7)),
                     6'd0, {$urandom, $urandom}, 4'($urandom_range(15)));
        // A small key and payload pool makes deduplication hits common.
        if ($urandom_range(3) != 0) op.payload = $urandom_range(3) * 64'h0101_0101_0101_0101;
        if ($urandom_range(9) == 0) begin
            op.type_id = 16'($urandom);
            op.content_hash = $urandom;
        end
        r = $urandom_range(99);
        if (r < 2) op.kind = KIND_CLEAR;
        else if (r < 3) op.kind = 3'($urandom_range(7, 6));
        if (op.kind inside {KIND_ADD_REF, KIND_RELEASE, KIND_QUERY}) begin
            op.slot_index = 6'($urandom);
            if (known_idx.size() > 0 && $urandom_range(9) < 8) begin
                j = $urandom_range(known_idx.size() - 1);
                op.slot_index = known_idx[j];
                op.content_hash = known_hash[j];
                if ($urandom_range(3) != 0) op.type_id = known_type[j];
            end
        end
        return op;
    endfunction

    // Receiver: random stalls, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) sb.check_answer(t_answer'(o_m_tdata[OUT_W-1:0]));
            i_m_tready <= !hold_off && !(idle_enable && $urandom_range(99) < 14);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (n_items >= 300);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb = new();
        sb.empty_table();
        idle_enable = 1'b0;
        n_items = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_CLEAR;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every kind, field extremes, rejections and the special cases.
        send_op(make_op(KIND_FIND, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_op(make_op(KIND_QUERY, 0, 0, 0, 0, 0));
        send_op(make_op(KIND_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, '1, 4'hF));
        send_op(make_op(KIND_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 0, '1, 8));
        send_op(make_op(KIND_ACQUIRE, 0, 0, 0, 64'h1122_3344_5566_7788, 0));
        send_op(make_op(KIND_ACQUIRE, 0, 0, 0, 64'hAA, 1));
        send_op(make_op(KIND_FIND, 0, 0, 0, 0, 0));
        send_op(make_op(KIND_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_op(make_op(KIND_QUERY, 16'h1234, 32'hFFFF_FFFF, 0, 0, 0));
        send_op(make_op(KIND_QUERY, 0, 0, 1, 0, 0));
        send_op(make_op(KIND_ADD_REF, 0, 0, 6'h3F, 0, 0));
        send_op(make_op(KIND_ADD_REF, 0, 32'h5, 1, 0, 0));
        send_op(make_op(KIND_RELEASE, 0, 0, 2, 0, 0));
        send_op(make_op(KIND_FIND, 0, 0, 0, 0, 0));
        send_op(make_op(KIND_RELEASE, 0, 0, 1, 0, 0));
        send_op(make_op(KIND_RELEASE, 0, 0, 1, 0, 0));
        send_op(make_op(KIND_ACQUIRE, 3, 3, 0, 64'h55, 2));
        send_op(make_op(3'd6, 0, 0, 0, 0, 0));
        send_op(make_op(3'd7, 0, 0, 0, 0, 0));
        send_op(make_op(KIND_CLEAR, 0, 0, 0, 0, 0));
        // Fill the table, then one more distinct key reports full.
        for (int i = 0; i <= SLOTS; i++)
            send_op(make_op(KIND_ACQUIRE, 16'h8000, 32'(i), 0, 64'(i), 4));
        send_op(make_op(KIND_RELEASE, 16'h8000, 7, 7, 0, 0));
        send_op(make_op(KIND_ACQUIRE, 16'h8000, 99, 0, 0, 0));
        send_op(make_op(KIND_CLEAR, 0, 0, 0, 0, 0));
        // Raise one count by add_ref and by a reused acquire.
        send_op(make_op(KIND_ACQUIRE, 1, 1, 0, 64'h77, 1));
        repeat (3) send_op(make_op(KIND_ADD_REF, 1, 1, 0, 0, 0));
        send_op(make_op(KIND_ACQUIRE, 1, 1, 0, 64'h77, 1));
        send_op(make_op(KIND_QUERY, 1, 1, 0, 0, 0));
        send_op(make_op(KIND_CLEAR, 0, 0, 0, 0, 0));

        // Random part: a calm stretch first, then random gaps on both sides.
        for (int i = 0; i < 1055; i++) begin
            if (i == 150) idle_enable = 1'b1;
            send_op(random_op());
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Checked %0d answers: %0d reused acquires, %0d table-full answers,",
                 sb.checked, sb.n_reused, sb.n_full);
        $display("with releases to zero, stalls on both sides and a long receiver hold-off.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
